>>> rtl/nested_region_timer_table_macros.svh
// Assertion macros shared by the region timer table.
`ifndef NESTED_REGION_TIMER_TABLE_MACROS_SVH
`define NESTED_REGION_TIMER_TABLE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define NRTT_ASSERT_IMP(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("nrtt assertion failed");
// Next-cycle implication checked outside reset.
`define NRTT_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("nrtt assertion failed");
`endif

>>> rtl/nrtt_pkg.sv
// Package with word types, codes and cell interface structs of the region timer table.
`default_nettype none
package nrtt_pkg;
  localparam int KEY_W = 16;
  localparam int DEPTH_W = 8;
  localparam int FIELD_TIME_W = 48;

  typedef enum logic [2:0] {
    MODE_BEGIN = 3'd0,
    MODE_END   = 3'd1,
    MODE_CLEAR = 3'd2,
    MODE_READ  = 3'd3,
    MODE_INIT  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_UNKNOWN  = 3'd2,
    ST_NOTBEGUN = 3'd3,
    ST_OPEN     = 3'd4,
    ST_OVERFLOW = 3'd5,
    ST_INACTIVE = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]              mode;
    logic [KEY_W-1:0]        tag_key;
    logic [3:0]              slot_select;
    logic [FIELD_TIME_W-1:0] now_ticks;
  } in_word_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [3:0]              slot_used;
    logic [FIELD_TIME_W-1:0] total_ticks;
    logic [DEPTH_W-1:0]      depth_now;
    logic [4:0]              active_count;
  } out_word_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic             apply;   // perform the operation this cycle
    logic [2:0]       mode;
    logic [KEY_W-1:0] key;
  } cell_cmd_t;

  // Chain signals passed from one cell to the next.
  typedef struct packed {
    logic hit_before;    // a lower cell matches the key
    logic free_before;   // a lower cell is free
    logic open_before;   // a lower cell is in use and open
  } chain_t;
endpackage
`default_nettype wire

>>> rtl/nested_region_timer_table.sv
// Top level of the region timer table: controller, result register and cell chain.
// A word is accepted only while the controller is idle. In the cycle after acceptance the
// key is matched across the chain of slot cells, the cells are updated and the result is
// registered; the result is presented in the next cycle and is held while out_stall is
// high. The next word can be accepted in the cycle after the result is taken, so a new
// word is not taken before the last result has left.
`default_nettype none
module nested_region_timer_table
  import nrtt_pkg::*;
#(
  parameter int TAG_SLOTS = 16,
  parameter int TIME_BITS = 48
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);
  `include "nested_region_timer_table_macros.svh"

  localparam int SW = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;
  localparam int CW = $clog2(TAG_SLOTS + 1);

  state_e   state, state_next;
  in_word_t req;
  cell_cmd_t cmd;
  chain_t   chain [TAG_SLOTS+1];
  logic [TAG_SLOTS-1:0] use_v, hit_v, claim_v, open_v;
  logic [DEPTH_W-1:0]   depth_a [TAG_SLOTS];
  logic [TIME_BITS-1:0] total_a [TAG_SLOTS];
  logic [TIME_BITS-1:0] now_t;
  logic any_hit, any_claim, any_open;
  logic [SW-1:0] hit_idx, claim_idx, open_idx, sel_idx;
  logic sel_ok;
  logic [CW-1:0] cnt_after;
  out_word_t res, res_next;

  assign now_t = TIME_BITS'(req.now_ticks);
  assign any_hit   = |hit_v;
  assign any_claim = |claim_v;
  assign any_open  = |open_v;
  assign chain[0]  = '0;

  // Command broadcast to the cells.
  assign cmd.apply  = (state == S_APPLY);
  assign cmd.mode   = req.mode;
  assign cmd.key    = req.tag_key;

  // Row of slot cells.
  for (genvar g = 0; g < TAG_SLOTS; g++) begin : g_cell
    nrtt_cell #(.TIME_W(TIME_BITS)) u_cell (
      .clk, .rst, .cmd, .now(now_t), .chain_in(chain[g]), .any_hit,
      .chain_out(chain[g+1]), .in_use(use_v[g]), .hit(hit_v[g]), .claim(claim_v[g]),
      .open_first(open_v[g]), .depth(depth_a[g]), .total(total_a[g])
    );
  end

  // One-hot encoders of the hit, claim and open vectors.
  always_comb begin
    hit_idx = '0; claim_idx = '0; open_idx = '0;
    for (int i = 0; i < TAG_SLOTS; i++) begin
      if (hit_v[i])   hit_idx   = SW'(i);
      if (claim_v[i]) claim_idx = SW'(i);
      if (open_v[i])  open_idx  = SW'(i);
    end
  end

  assign sel_ok  = (32'(req.slot_select) < 32'(TAG_SLOTS));
  assign sel_idx = SW'(req.slot_select);

  // Result word, computed from the state before the update.
  always_comb begin
    logic [DEPTH_W-1:0] d;
    logic [SW-1:0] ix;
    logic [CW-1:0] c;
    c = '0;
    for (int i = 0; i < TAG_SLOTS; i++) c = c + CW'(use_v[i]);
    ix = any_hit ? hit_idx : claim_idx;
    d  = any_hit ? depth_a[hit_idx] : '0;
    cnt_after = c;
    res_next = '0;
    unique case (req.mode)
      MODE_BEGIN: begin
        if (!any_hit && !any_claim) res_next.status = ST_FULL;
        else begin
          if (!any_hit) cnt_after = c + 1'b1;
          res_next.slot_used = 4'(ix);
          if (d == '1) begin
            res_next.status = ST_OVERFLOW;
            res_next.depth_now = d;
          end else res_next.depth_now = d + 1'b1;
        end
      end
      MODE_END: begin
        if (!any_hit) res_next.status = ST_UNKNOWN;
        else begin
          res_next.slot_used = 4'(hit_idx);
          if (d == '0) res_next.status = ST_NOTBEGUN;
          else res_next.depth_now = d - 1'b1;
        end
      end
      MODE_CLEAR: begin
        if (any_open) begin
          res_next.status = ST_OPEN;
          res_next.slot_used = 4'(open_idx);
          res_next.depth_now = depth_a[open_idx];
        end
      end
      MODE_READ: begin
        res_next.slot_used = req.slot_select;
        if (!sel_ok || !use_v[sel_idx]) res_next.status = ST_INACTIVE;
        else begin
          res_next.depth_now = depth_a[sel_idx];
          if (depth_a[sel_idx] != '0) res_next.status = ST_OPEN;
          else res_next.total_ticks = FIELD_TIME_W'(total_a[sel_idx]);
        end
      end
      MODE_INIT: cnt_after = '0;
      default: ;
    endcase
    res_next.active_count = 5'(cnt_after);
  end

  // Controller state register.
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_APPLY;
      S_APPLY: state_next = S_OUT;
      S_OUT:   if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_word  = res;

  // Word capture and result register.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) req <= in_word;
    if (state == S_APPLY) res <= res_next;
  end

  `NRTT_ASSERT_IMP(a_one_hit, clk, rst, state == S_APPLY, $onehot0(hit_v))
  `NRTT_ASSERT_IMP(a_one_claim, clk, rst, state == S_APPLY, $onehot0(claim_v))
  `NRTT_ASSERT_NEXT(a_apply_out, clk, rst, state == S_APPLY, out_valid)
  `NRTT_ASSERT_IMP(a_busy_stall, clk, rst, out_valid, in_stall)
endmodule
`default_nettype wire

>>> rtl/nrtt_cell.sv
// One slot cell of the region timer table.
`default_nettype none
module nrtt_cell
  import nrtt_pkg::*;
#(
  parameter int TIME_W = 48
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cell_cmd_t         cmd,
  input  wire logic [TIME_W-1:0] now,
  input  wire chain_t            chain_in,
  input  wire logic              any_hit,
  output chain_t                 chain_out,
  output logic                   in_use,
  output logic                   hit,
  output logic                   claim,
  output logic                   open_first,
  output logic [DEPTH_W-1:0]     depth,
  output logic [TIME_W-1:0]      total
);
  localparam logic [TIME_W-1:0] TMAX = '1;

  logic [KEY_W-1:0]  key;
  logic [TIME_W-1:0] start;
  logic              match;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W:0]   sum;

  // Key match and chain priority terms.
  assign match      = in_use && (key == cmd.key);
  assign hit        = match && !chain_in.hit_before;
  assign claim      = !in_use && !chain_in.free_before && !any_hit;
  assign open_first = in_use && (depth != '0) && !chain_in.open_before;
  assign chain_out.hit_before  = chain_in.hit_before || match;
  assign chain_out.free_before = chain_in.free_before || !in_use;
  assign chain_out.open_before = chain_in.open_before || (in_use && depth != '0);

  // Elapsed time and saturating sum.
  assign elapsed = now - start;
  assign sum     = {1'b0, total} + {1'b0, elapsed};

  // Slot state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= 1'b0;
      depth  <= '0;
      start  <= '0;
      total  <= '0;
    end else if (cmd.apply) begin
      case (cmd.mode)
        MODE_BEGIN: begin
          if (hit) begin
            if (depth != '1) begin
              if (depth == '0) start <= now;
              depth <= depth + 1'b1;
            end
          end else if (claim) begin
            in_use <= 1'b1;
            key    <= cmd.key;
            total  <= '0;
            start  <= now;
            depth  <= DEPTH_W'(1);
          end
        end
        MODE_END: begin
          if (hit && depth != '0) begin
            depth <= depth - 1'b1;
            if (depth == DEPTH_W'(1)) total <= sum[TIME_W] ? TMAX : sum[TIME_W-1:0];
          end
        end
        MODE_CLEAR: begin
          if (in_use && depth == '0 && !chain_in.open_before) begin
            start <= '0;
            total <= '0;
          end
        end
        MODE_INIT: begin
          in_use <= 1'b0;
          depth  <= '0;
          start  <= '0;
          total  <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> tb/sv/tb_nested_region_timer_table.sv
// Self-checking testbench of the nested region timer table.
`default_nettype none
module tb_nested_region_timer_table;
  import nrtt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [47:0] TICK_MAX = 48'hFFFF_FFFF_FFFF;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  nested_region_timer_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always #4 clk = ~clk;

  // Shadow copy of the slot table.
  logic        tbl_used  [SLOTS];
  logic [15:0] tbl_key   [SLOTS];
  logic [7:0]  tbl_depth [SLOTS];
  logic [47:0] tbl_start [SLOTS];
  logic [47:0] tbl_total [SLOTS];

  in_word_t  pending_words[$];
  out_word_t expected_results[$];
  int        error_count = 0;
  int        cycle_count = 0;
  int        words_sent = 0;
  int        results_seen = 0;
  bit        drain_hold = 1'b0;
  int        mode_hits[8];

  // Applies one word to the shadow table and returns the expected result.
  function automatic out_word_t timer_table_step(in_word_t w);
    out_word_t r;
    int idx;
    int n;
    logic [48:0] sum;
    logic [47:0] elapsed;
    r = '0;
    idx = -1;
    case (w.mode)
      MODE_BEGIN, MODE_END: begin
        for (int i = 0; i < SLOTS; i++)
          if (idx < 0 && tbl_used[i] && tbl_key[i] == w.tag_key) idx = i;
        if (w.mode == MODE_BEGIN) begin
          if (idx < 0) begin
            for (int i = 0; i < SLOTS; i++)
              if (idx < 0 && !tbl_used[i]) idx = i;
            if (idx >= 0) begin
              tbl_used[idx] = 1'b1;
              tbl_key[idx] = w.tag_key;
              tbl_total[idx] = '0;
              tbl_start[idx] = '0;
              tbl_depth[idx] = '0;
            end
          end
          if (idx < 0) begin
            r.status = ST_FULL;
          end else begin
            r.slot_used = idx[3:0];
            if (tbl_depth[idx] == 8'd255) begin
              r.status = ST_OVERFLOW;
            end else begin
              if (tbl_depth[idx] == 0) tbl_start[idx] = w.now_ticks;
              tbl_depth[idx]++;
            end
            r.depth_now = tbl_depth[idx];
          end
        end else if (idx < 0) begin
          r.status = ST_UNKNOWN;
        end else begin
          r.slot_used = idx[3:0];
          if (tbl_depth[idx] == 0) begin
            r.status = ST_NOTBEGUN;
          end else begin
            tbl_depth[idx]--;
            if (tbl_depth[idx] == 0) begin
              elapsed = w.now_ticks - tbl_start[idx];
              sum = {1'b0, tbl_total[idx]} + {1'b0, elapsed};
              tbl_total[idx] = sum[48] ? TICK_MAX : sum[47:0];
            end
            r.depth_now = tbl_depth[idx];
          end
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (idx < 0 && tbl_used[i]) begin
            if (tbl_depth[i] != 0) begin
              idx = i;
              r.status = ST_OPEN;
              r.slot_used = i[3:0];
              r.depth_now = tbl_depth[i];
            end else begin
              tbl_start[i] = '0;
              tbl_total[i] = '0;
            end
          end
        end
      end
      MODE_READ: begin
        r.slot_used = w.slot_select;
        if (!tbl_used[w.slot_select]) begin
          r.status = ST_INACTIVE;
        end else begin
          r.depth_now = tbl_depth[w.slot_select];
          if (r.depth_now != 0) r.status = ST_OPEN;
          else r.total_ticks = tbl_total[w.slot_select];
        end
      end
      MODE_INIT: begin
        for (int i = 0; i < SLOTS; i++) begin
          tbl_used[i] = 1'b0;
          tbl_depth[i] = '0;
          tbl_start[i] = '0;
          tbl_total[i] = '0;
        end
      end
      default: ;
    endcase
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (tbl_used[i]) n++;
    r.active_count = n[4:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    $display("mismatch at result %0d: %s got %0h expected %0h", results_seen, what, got, want);
  endtask

  function automatic int gap_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Driver: presents queued words, with random gaps between them.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      mode_hits[in_word.mode]++;
      expected_results.push_back(timer_table_step(in_word));
      words_sent++;
      send_gap = gap_length();
      if (send_gap == 0 && pending_words.size() > 0 && !drain_hold) begin
        in_word <= pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_words.size() > 0 && !drain_hold) begin
        in_word <= pending_words.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Monitor: compares every result word with the oldest expectation.
  int stall_left = 0;
  always @(posedge clk) begin
    out_word_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word", 64'(out_word.total_ticks), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_word.status != want.status)
            report_mismatch("status", 64'(out_word.status), 64'(want.status));
          if (out_word.slot_used != want.slot_used)
            report_mismatch("slot_used", 64'(out_word.slot_used), 64'(want.slot_used));
          if (out_word.total_ticks != want.total_ticks)
            report_mismatch("total_ticks", 64'(out_word.total_ticks),
                            64'(want.total_ticks));
          if (out_word.depth_now != want.depth_now)
            report_mismatch("depth_now", 64'(out_word.depth_now), 64'(want.depth_now));
          if (out_word.active_count != want.active_count)
            report_mismatch("active_count", 64'(out_word.active_count),
                            64'(want.active_count));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = gap_length();
        out_stall <= (stall_left > 0);
      end
    end
  end

  // Cycle limit guards against a hung block.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic in_word_t make_word(mode_e m, logic [15:0] k, logic [3:0] s,
                                         logic [47:0] t);
    in_word_t w;
    w.mode = m;
    w.tag_key = k;
    w.slot_select = s;
    w.now_ticks = t;
    return w;
  endfunction

  function automatic logic [47:0] rand_ticks();
    return 48'({$urandom(), $urandom()});
  endfunction

  // Random nested sessions over eight keys, with a few stray words mixed in.
  task automatic queue_random_words(int count);
    logic [15:0] keys[8];
    int          open_depth[8];
    logic [47:0] clock_now;
    int          k;
    int          p;
    in_word_t    w;
    clock_now = rand_ticks();
    for (int i = 0; i < 8; i++) begin
      keys[i] = 16'($urandom());
      open_depth[i] = 0;
    end
    for (int n = 0; n < count; n++) begin
      clock_now += $urandom_range(0, 1) ? 48'($urandom_range(0, 1000))
                                        : {$urandom(), 16'h0};
      k = $urandom_range(0, 7);
      p = $urandom_range(0, 99);
      if (p < 40) begin
        w = make_word(MODE_BEGIN, keys[k], 4'($urandom()), clock_now);
        open_depth[k]++;
      end else if (p < 75) begin
        w = make_word(MODE_END, keys[k], 4'($urandom()), clock_now);
        if (open_depth[k] > 0) open_depth[k]--;
      end else if (p < 85) begin
        w = make_word(MODE_READ, 16'($urandom()), 4'($urandom()), rand_ticks());
      end else if (p < 90) begin
        w = make_word(MODE_CLEAR, 16'($urandom()), 4'($urandom()), rand_ticks());
      end else if (p < 92) begin
        w = make_word(MODE_INIT, 16'($urandom()), 4'($urandom()), rand_ticks());
        for (int i = 0; i < 8; i++) open_depth[i] = 0;
      end else if (p < 97) begin
        // Stray key: unknown end or a fresh claim.
        w = make_word(mode_e'(3'($urandom_range(0, 1))), 16'($urandom()),
                      4'($urandom()), rand_ticks());
      end else begin
        w = make_word(mode_e'(3'($urandom_range(5, 7))), 16'($urandom()),
                      4'($urandom()), rand_ticks());
      end
      pending_words.push_back(w);
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_used[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_depth[i] = '0;
      tbl_start[i] = '0;
      tbl_total[i] = '0;
    end
    for (int i = 0; i < 8; i++) mode_hits[i] = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part: extremes, errors on an empty table, saturation and unknown modes.
    pending_words.push_back(make_word(MODE_END, 16'hFFFF, 4'hF, TICK_MAX));
    pending_words.push_back(make_word(MODE_READ, 16'h0, 4'hF, 48'h0));
    pending_words.push_back(make_word(MODE_BEGIN, 16'h0000, 4'h0, 48'h0));
    pending_words.push_back(make_word(MODE_BEGIN, 16'hFFFF, 4'hF, TICK_MAX));
    pending_words.push_back(make_word(MODE_READ, 16'h0, 4'h0, 48'h0));
    pending_words.push_back(make_word(MODE_CLEAR, 16'h0, 4'h0, 48'h0));
    pending_words.push_back(make_word(MODE_END, 16'hFFFF, 4'h0, 48'h5));
    pending_words.push_back(make_word(MODE_END, 16'hFFFF, 4'h0, 48'h9));
    pending_words.push_back(make_word(MODE_END, 16'h0000, 4'h0, TICK_MAX));
    pending_words.push_back(make_word(MODE_BEGIN, 16'h0000, 4'h0, 48'h0));
    pending_words.push_back(make_word(MODE_END, 16'h0000, 4'h0, TICK_MAX));
    pending_words.push_back(make_word(MODE_READ, 16'h0, 4'h0, 48'h0));
    pending_words.push_back(make_word(MODE_READ, 16'h0, 4'h1, 48'h0));
    pending_words.push_back(make_word(MODE_CLEAR, 16'h0, 4'h0, 48'h0));
    pending_words.push_back(make_word(MODE_READ, 16'h0, 4'h0, 48'h0));
    pending_words.push_back(make_word(mode_e'(3'd5), 16'h1234, 4'h3, 48'h1));
    pending_words.push_back(make_word(mode_e'(3'd7), 16'hABCD, 4'hC, TICK_MAX));
    pending_words.push_back(make_word(MODE_INIT, 16'h0, 4'h0, 48'h0));
    // Fill every slot, then one more claim finds the table full.
    for (int i = 0; i <= SLOTS; i++)
      pending_words.push_back(make_word(MODE_BEGIN, 16'(i + 100), 4'h0, 48'(i)));
    pending_words.push_back(make_word(MODE_CLEAR, 16'h0, 4'h0, 48'h0));
    pending_words.push_back(make_word(MODE_INIT, 16'h0, 4'h0, 48'h0));
    // Nest one key to the depth limit for the overflow case, then unwind.
    for (int i = 0; i < 256; i++)
      pending_words.push_back(make_word(MODE_BEGIN, 16'h5A5A, 4'h0, 48'(i)));
    for (int i = 0; i < 256; i++)
      pending_words.push_back(make_word(MODE_END, 16'h5A5A, 4'h0, rand_ticks()));
    pending_words.push_back(make_word(MODE_READ, 16'h0, 4'h0, 48'h0));

    queue_random_words(425);
    wait_drained();

    // Every result is in; hold the sender for a pause, then continue.
    drain_hold = 1'b1;
    repeat (10) @(posedge clk);
    drain_hold = 1'b0;
    queue_random_words(425);
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Sent %0d words: begin %0d, end %0d, clear %0d, read %0d, init %0d.",
             words_sent, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
             mode_hits[4]);
    $display("Checked %0d results including full table, overflow and saturation cases.",
             results_seen);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
`default_nettype wire
